// ===== rtl/twodo_pkg.sv =====
// ----------------------------------------------------------------------------
// twodo_pkg
// Shared types, register indexes and fixed-point constants of the odometry
// pose tracker.
// ----------------------------------------------------------------------------
package twodo_pkg;

	// angle argument of the trig unit, half-centidegrees
	localparam int ANG_W = 18;
	// sin/cos results in Q30
	localparam int TRIG_W = 34;
	localparam int CORDIC_STEPS = 30;

	// configuration register indexes
	localparam logic [1:0] REG_WHEEL_RADIUS = 2'd0;
	localparam logic [1:0] REG_FWD_OFFSET = 2'd1;
	localparam logic [1:0] REG_SIDE_OFFSET = 2'd2;

	// request kinds
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_SET_POSE = 1'b1;

	// radians per centidegree, Q32 and Q30
	localparam logic [19:0] RAD_PER_CD_Q32 = 20'd749613;
	localparam logic [17:0] RAD_PER_CD_Q30 = 18'd187403;

	// sequencer of the pose update
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ARC,
		ST_SPLIT,
		ST_TRIG1,
		ST_THETA,
		ST_DIV,
		ST_LOC,
		ST_TRIG2,
		ST_GLB,
		ST_DONE
	} state_t;

	// trig unit sequencer
	typedef enum logic [1:0] {
		CS_IDLE,
		CS_ZLOAD,
		CS_ITER
	} cordic_state_t;

	// trig unit status and results
	typedef struct packed {
		logic busy;
		logic done;
		logic signed [TRIG_W-1:0] sin_v;
		logic signed [TRIG_W-1:0] cos_v;
	} trig_res_t;

	// arctangent of 2^-i, Q30 radians
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] v;
		begin
			case (i)
				5'd0: v = 30'd843314857;
				5'd1: v = 30'd497837829;
				5'd2: v = 30'd263043837;
				5'd3: v = 30'd133525159;
				5'd4: v = 30'd67021687;
				5'd5: v = 30'd33543516;
				5'd6: v = 30'd16775851;
				5'd7: v = 30'd8388437;
				5'd8: v = 30'd4194283;
				5'd9: v = 30'd2097149;
				default: v = 30'd1 << (5'd30 - i);
			endcase
			return v;
		end
	endfunction

endpackage

// ===== rtl/twodo_cordic.sv =====
// ----------------------------------------------------------------------------
// twodo_cordic
// Iterative rotation-mode trig unit: sin and cos in Q30 of an angle given in
// half-centidegrees, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module twodo_cordic
	import twodo_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ANG_W-1:0] angle,
	output trig_res_t               res
);

	localparam logic signed [18:0] TURN = 19'sd72000;
	localparam logic signed [18:0] HALF = 19'sd36000;
	localparam logic signed [18:0] QUARTER = 19'sd18000;
	localparam logic signed [19:0] Z_SCALE = 20'sd374807;
	localparam logic signed [TRIG_W-1:0] GAIN = 34'sd652032874;

	cordic_state_t state_q, state_d;
	logic [4:0] step_q;
	logic done_q;
	logic neg_q;
	logic signed [15:0] a_q;
	logic signed [33:0] z_q;
	logic signed [TRIG_W-1:0] x_q, y_q;

	logic signed [18:0] a0, a1, a2, a3;
	logic neg_d;
	logic signed [35:0] z_prod;
	logic signed [TRIG_W-1:0] x_sh, y_sh;
	logic signed [33:0] atan_v;

	// fold the angle into the range of plus or minus a quarter turn
	always_comb begin
		a0 = 19'(angle);
		if (a0 < 19'sd0)
			a1 = a0 + TURN;
		else if (a0 >= TURN)
			a1 = a0 - TURN;
		else
			a1 = a0;
		a2 = (a1 >= HALF) ? a1 - TURN : a1;
		neg_d = 1'b0;
		a3 = a2;
		if (a2 > QUARTER) begin
			a3 = a2 - HALF;
			neg_d = 1'b1;
		end else if (a2 < -QUARTER) begin
			a3 = a2 + HALF;
			neg_d = 1'b1;
		end
	end

	assign z_prod = 36'(a_q) * 36'(Z_SCALE);
	assign x_sh = x_q >>> step_q;
	assign y_sh = y_q >>> step_q;
	assign atan_v = $signed({4'b0, atan_q30(step_q)});

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (start)
					state_d = CS_ZLOAD;
			end
			CS_ZLOAD: begin
				state_d = CS_ITER;
			end
			CS_ITER: begin
				if (step_q == 5'(CORDIC_STEPS - 1))
					state_d = CS_IDLE;
			end
			default: state_d = CS_IDLE;
		endcase
	end

	// done flag and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= (state_q == CS_ITER) && (step_q == 5'(CORDIC_STEPS - 1));
			if (state_q == CS_ITER)
				step_q <= step_q + 5'd1;
			else
				step_q <= '0;
		end
	end

	// angle, rotation vector and residual angle
	always_ff @(posedge clk) begin
		unique case (state_q)
			CS_IDLE: begin
				if (start) begin
					a_q <= a3[15:0];
					neg_q <= neg_d;
				end
			end
			CS_ZLOAD: begin
				z_q <= z_prod[35:2];
				x_q <= GAIN;
				y_q <= '0;
			end
			CS_ITER: begin
				if (!z_q[33]) begin
					x_q <= x_q - y_sh;
					y_q <= y_q + x_sh;
					z_q <= z_q - atan_v;
				end else begin
					x_q <= x_q + y_sh;
					y_q <= y_q - x_sh;
					z_q <= z_q + atan_v;
				end
			end
			default: ;
		endcase
	end

	assign res.busy = (state_q != CS_IDLE);
	assign res.done = done_q;
	assign res.sin_v = neg_q ? -y_q : y_q;
	assign res.cos_v = neg_q ? -x_q : x_q;

endmodule

// ===== rtl/twodo_div.sv =====
// ----------------------------------------------------------------------------
// twodo_div
// Restoring divider for the chord-to-arc ratio: quotient of num * 2^30 by den,
// one quotient bit per cycle. The quotient is known to fit in 32 bits.
// ----------------------------------------------------------------------------
module twodo_div
	import twodo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [33:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quo
);

	logic busy_q;
	logic done_q;
	logic [4:0] cnt_q;
	logic [31:0] rem_q;
	logic [31:0] lo_q;
	logic [31:0] den_q;
	logic [31:0] quo_q;
	logic [32:0] trial;
	logic fits;

	assign trial = {rem_q, lo_q[31]};
	assign fits = (trial >= {1'b0, den_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient, the top bits of num * 2^30 preload the remainder
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= num[33:2];
			lo_q <= {num[1:0], 30'b0};
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			lo_q <= {lo_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

// ===== rtl/tracking_wheel_odometry.sv =====
// ----------------------------------------------------------------------------
// tracking_wheel_odometry
// Dead-reckoning pose tracker from two tracking wheels and an IMU heading.
//
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   encoder angles, heading, pose, op, calib
// m_*      out  m_tvalid/m_tready   pos_x, pos_y, updated
// cfg_*    in   cfg_we              wheel radius and wheel offsets
//
// set pose and skipped update: straight from request to result, no arithmetic
// update with no heading change: arcs, one trig pass, rotation
// update with heading change: arcs, two 30-step trig passes, the 32-step
//   divider and rotation; the other steps share one 35x34 multiplier
// s_tready is high only while the sequencer is idle; a result waiting on
//   m_tready holds the next result back but not the next request
// reset clears the pose, encoder history and registers to their defaults
// ----------------------------------------------------------------------------
module tracking_wheel_odometry
	import twodo_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// forward_angle, sideways_angle, heading, new_x, new_y
	input  logic [143:0] s_tdata,
	// op, imu_calibrating
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pos_x, pos_y
	output logic [63:0]  m_tdata,
	// updated
	output logic [0:0]   m_tuser,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [23:0]  cfg_wdata
);

	localparam logic [15:0] FULL_CD = 16'd36000;
	localparam logic signed [16:0] HALF_CD = 17'sd18000;
	localparam logic signed [16:0] FULL_CD_S = 17'sd36000;

	// registers and pose state
	logic [23:0] radius_q;
	logic signed [23:0] fwd_off_q, side_off_q;
	logic [31:0] last_fa_q, last_sa_q;
	logic [15:0] last_h_q;
	logic signed [31:0] gx_q, gy_q;

	// request fields
	logic op_in, calib_in;
	logic [31:0] fa_in, sa_in, nx_in, ny_in;
	logic [15:0] hd_in, h_in;
	logic signed [16:0] dh_raw, dh_in;

	assign op_in = s_tuser[0];
	assign calib_in = s_tuser[1];
	assign fa_in = s_tdata[31:0];
	assign sa_in = s_tdata[63:32];
	assign hd_in = s_tdata[79:64];
	assign nx_in = s_tdata[111:80];
	assign ny_in = s_tdata[143:112];

	// reduced heading and wrapped heading delta
	always_comb begin
		h_in = (hd_in >= FULL_CD) ? hd_in - FULL_CD : hd_in;
		dh_raw = $signed({1'b0, h_in}) - $signed({1'b0, last_h_q});
		if (dh_raw > HALF_CD)
			dh_in = dh_raw - FULL_CD_S;
		else if (dh_raw <= -HALF_CD)
			dh_in = dh_raw + FULL_CD_S;
		else
			dh_in = dh_raw;
	end

	// sequencer
	state_t state_q, state_d;
	logic [2:0] step_q;
	logic wsel_q;
	logic accept, out_load;
	logic cordic_start, div_start;
	logic signed [ANG_W-1:0] cordic_angle;

	// working registers
	logic upd_q;
	logic signed [31:0] dlt_f_q, dlt_s_q;
	logic signed [16:0] dh_q;
	logic [15:0] h_q;
	logic neg_q;
	logic [54:0] mag_q;
	logic [50:0] hi_q;
	logic [42:0] r_q;
	logic signed [31:0] df_q, ds_q;
	logic signed [33:0] s2_q;
	logic signed [34:0] lx_q, ly_q;
	logic signed [39:0] ax_q, ay_q;

	// shared multiplier
	logic signed [34:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [68:0] prod_q;
	logic signed [68:0] prod_abs;
	logic signed [38:0] p_sh;
	logic signed [39:0] p_ext;

	// output register
	logic out_valid_q;
	logic signed [31:0] out_x_q, out_y_q;
	logic out_upd_q;

	// units
	trig_res_t trig;
	logic div_done;
	logic [31:0] div_quo;
	logic [33:0] us2;
	logic [14:0] adh;
	logic [31:0] uth;
	logic signed [ANG_W-1:0] mid_angle;

	// arc length helpers
	logic [74:0] arc_sum;
	logic signed [31:0] arc_val;

	assign accept = s_tvalid && s_tready;
	assign prod_abs = prod_q[68] ? -prod_q : prod_q;
	assign p_sh = prod_q[68:30];
	assign p_ext = 40'(p_sh);
	assign arc_sum = {hi_q, 24'b0} + {31'b0, prod_q[43:0]};
	assign us2 = s2_q[33] ? 34'(-s2_q) : 34'(s2_q);
	assign adh = dh_q[16] ? 15'(-dh_q) : 15'(dh_q);
	assign uth = 32'({17'b0, adh} * {14'b0, RAD_PER_CD_Q30});
	assign mid_angle = $signed({2'b0, h_q} << 1) - 18'(dh_q);

	// saturated signed arc length
	always_comb begin
		if (!neg_q)
			arc_val = (r_q > 43'd2147483647) ? 32'sh7fffffff : $signed(r_q[31:0]);
		else
			arc_val = (r_q > 43'd2147483648) ? 32'sh80000000 : -$signed(r_q[31:0]);
	end

	// saturate a 40-bit sum to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		begin
			if (v > 40'sd2147483647)
				r = 32'sh7fffffff;
			else if (v < -40'sd2147483648)
				r = 32'sh80000000;
			else
				r = v[31:0];
			return r;
		end
	endfunction

	twodo_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.angle  (cordic_angle),
		.res    (trig)
	);

	twodo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (us2),
		.den    (uth),
		.done   (div_done),
		.quo    (div_quo)
	);

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_ARC: begin
				case (step_q)
					3'd0: begin
						mul_a = 35'(wsel_q ? dlt_s_q : dlt_f_q);
						mul_b = $signed({10'b0, radius_q});
					end
					3'd2: begin
						mul_a = $signed({4'b0, mag_q[54:24]});
						mul_b = $signed({14'b0, RAD_PER_CD_Q32});
					end
					3'd3: begin
						mul_a = $signed({11'b0, mag_q[23:0]});
						mul_b = $signed({14'b0, RAD_PER_CD_Q32});
					end
					default: ;
				endcase
			end
			ST_LOC: begin
				case (step_q)
					3'd0: begin
						mul_a = $signed({3'b0, div_quo});
						mul_b = 34'(ds_q);
					end
					3'd1: begin
						mul_a = 35'(s2_q);
						mul_b = 34'(side_off_q);
					end
					3'd2: begin
						mul_a = $signed({3'b0, div_quo});
						mul_b = 34'(df_q);
					end
					3'd3: begin
						mul_a = 35'(s2_q);
						mul_b = 34'(fwd_off_q);
					end
					default: ;
				endcase
			end
			ST_GLB: begin
				case (step_q)
					3'd0: begin
						mul_a = ly_q;
						mul_b = trig.sin_v;
					end
					3'd1: begin
						mul_a = lx_q;
						mul_b = trig.cos_v;
					end
					3'd2: begin
						mul_a = ly_q;
						mul_b = trig.cos_v;
					end
					3'd3: begin
						mul_a = lx_q;
						mul_b = trig.sin_v;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// product register
	always_ff @(posedge clk) begin
		prod_q <= 69'(mul_a) * 69'(mul_b);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and unit starts
	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		cordic_start = 1'b0;
		div_start = 1'b0;
		out_load = 1'b0;
		cordic_angle = mid_angle;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (op_in == OP_SET_POSE || calib_in)
						state_d = ST_DONE;
					else
						state_d = ST_ARC;
				end
			end
			ST_ARC: begin
				if (step_q == 3'd5 && wsel_q)
					state_d = ST_SPLIT;
			end
			ST_SPLIT: begin
				cordic_start = 1'b1;
				if (dh_q == 17'sd0) begin
					state_d = ST_TRIG2;
				end else begin
					cordic_angle = 18'(dh_q);
					state_d = ST_TRIG1;
				end
			end
			ST_TRIG1: begin
				if (trig.done)
					state_d = ST_THETA;
			end
			ST_THETA: begin
				div_start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_done)
					state_d = ST_LOC;
			end
			ST_LOC: begin
				if (step_q == 3'd4) begin
					cordic_start = 1'b1;
					state_d = ST_TRIG2;
				end
			end
			ST_TRIG2: begin
				if (trig.done)
					state_d = ST_GLB;
			end
			ST_GLB: begin
				if (step_q == 3'd5)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// step counter of the multiply sequences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			wsel_q <= 1'b0;
		end else begin
			if (state_q == ST_ARC && step_q == 3'd5) begin
				step_q <= '0;
				wsel_q <= 1'b1;
			end else if (state_q == ST_ARC || state_q == ST_LOC || state_q == ST_GLB) begin
				step_q <= step_q + 3'd1;
			end else begin
				step_q <= '0;
				wsel_q <= 1'b0;
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 24'd65536;
			fwd_off_q <= '0;
			side_off_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_WHEEL_RADIUS: radius_q <= cfg_wdata;
				REG_FWD_OFFSET: fwd_off_q <= $signed(cfg_wdata);
				REG_SIDE_OFFSET: side_off_q <= $signed(cfg_wdata);
				default: ;
			endcase
		end
	end

	// pose and encoder history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_fa_q <= '0;
			last_sa_q <= '0;
			last_h_q <= '0;
			gx_q <= '0;
			gy_q <= '0;
		end else if (accept) begin
			if (op_in == OP_SET_POSE) begin
				gx_q <= $signed(nx_in);
				gy_q <= $signed(ny_in);
				last_h_q <= h_in;
			end else if (!calib_in) begin
				last_fa_q <= fa_in;
				last_sa_q <= sa_in;
				last_h_q <= h_in;
			end
		end else if (state_q == ST_GLB && step_q == 3'd5) begin
			gx_q <= sat32(ax_q);
			gy_q <= sat32(ay_q);
		end
	end

	// working datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			upd_q <= (op_in == OP_SET_POSE) || !calib_in;
			dlt_f_q <= $signed(fa_in - last_fa_q);
			dlt_s_q <= $signed(sa_in - last_sa_q);
			dh_q <= dh_in;
			h_q <= h_in;
		end
		unique case (state_q)
			ST_ARC: begin
				case (step_q)
					3'd1: begin
						neg_q <= prod_q[68];
						mag_q <= prod_abs[54:0];
					end
					3'd3: hi_q <= prod_q[50:0];
					3'd4: r_q <= arc_sum[74:32];
					3'd5: begin
						if (wsel_q)
							ds_q <= arc_val;
						else
							df_q <= arc_val;
					end
					default: ;
				endcase
			end
			ST_SPLIT: begin
				lx_q <= 35'(ds_q);
				ly_q <= 35'(df_q);
			end
			ST_TRIG1: begin
				if (trig.done)
					s2_q <= trig.sin_v <<< 1;
			end
			ST_LOC: begin
				case (step_q)
					3'd1: lx_q <= p_sh[34:0];
					3'd2: lx_q <= lx_q + p_sh[34:0];
					3'd3: ly_q <= p_sh[34:0];
					3'd4: ly_q <= ly_q - p_sh[34:0];
					default: ;
				endcase
			end
			ST_GLB: begin
				case (step_q)
					3'd1: ax_q <= 40'(gx_q) + p_ext;
					3'd2: ax_q <= ax_q + p_ext;
					3'd3: ay_q <= 40'(gy_q) + p_ext;
					3'd4: ay_q <= ay_q - p_ext;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q <= gx_q;
			out_y_q <= gy_q;
			out_upd_q <= upd_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {out_y_q, out_x_q};
	assign m_tuser = out_upd_q;

endmodule

// ===== rtl/twodo_checker.sv =====
// ----------------------------------------------------------------------------
// twodo_checker
// Port-level checks of the odometry tracker, bound to the top level.
// ----------------------------------------------------------------------------
module twodo_checker
	import twodo_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [143:0] s_tdata,
	input logic [1:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [63:0]  m_tdata,
	input logic [0:0]   m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one request at a time
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// a new result only comes out of a busy sequencer
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without work");

	// a set pose with a free output shows the loaded pose, flagged as updated
	a_set_pose: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] && !m_tvalid |-> ##2
		(m_tvalid && m_tuser[0] && m_tdata == $past(s_tdata[143:80], 2)))
		else $error("set pose result wrong");

endmodule

bind tracking_wheel_odometry twodo_checker u_twodo_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== dv/tb_tracking_wheel_odometry.sv =====
// ----------------------------------------------------------------------------
// tb_tracking_wheel_odometry
// Self-checking bench for the odometry pose tracker. A scoreboard object keeps
// its own copy of the pose, encoder history and registers. For every accepted
// request it works out the expected pose, and it compares each result against
// the oldest pending pose. The run goes through several register settings,
// including the extremes, after directed requests. Each setting gets random
// requests; all but one get random gaps on both sides, one a long output stall.
// ----------------------------------------------------------------------------
module tb_tracking_wheel_odometry;
	import twodo_pkg::*;

	typedef struct {
		logic        op;
		logic        calib;
		logic [31:0] fwd;
		logic [31:0] side;
		logic [15:0] hdg;
		logic [31:0] nx;
		logic [31:0] ny;
	} odo_req_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic        upd;
	} pose_t;

	// pose predictor and pending-result store
	class pose_scoreboard;
		logic [23:0] radius;
		logic [23:0] fwd_off;
		logic [23:0] side_off;
		logic [31:0] prev_fwd;
		logic [31:0] prev_side;
		logic [15:0] prev_hdg;
		longint      gx;
		longint      gy;
		longint      atan_q30[30];
		pose_t       pending[$];
		int          errors;
		int          n_upd;
		int          n_pose;
		int          n_skip;

		function new();
			atan_q30 = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
				16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
				65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
				16, 8, 4, 2};
			radius = 24'd65536;
			fwd_off = '0;
			side_off = '0;
			prev_fwd = '0;
			prev_side = '0;
			prev_hdg = '0;
			gx = 0;
			gy = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [23:0] val);
			case (idx)
				REG_WHEEL_RADIUS: radius = val;
				REG_FWD_OFFSET: fwd_off = val;
				REG_SIDE_OFFSET: side_off = val;
				default: ;
			endcase
		endfunction

		function longint clip32(longint v);
			if (v > 64'sd2147483647)
				return 64'sd2147483647;
			if (v < -64'sd2147483648)
				return -64'sd2147483648;
			return v;
		endfunction

		// encoder delta to Q16.16 arc length, truncated toward zero
		function longint arc_len(logic [31:0] now, logic [31:0] was);
			longint d, p, r;
			longint unsigned mag, t;
			logic [31:0] diff;
			diff = now - was;
			d = longint'($signed(diff));
			p = d * longint'({40'd0, radius});
			mag = (p < 0) ? longint'(-p) : longint'(p);
			t = (mag >> 16) * 64'd749613 + (((mag & 64'hFFFF) * 64'd749613) >> 16);
			r = longint'(t >> 16);
			return clip32((p < 0) ? -r : r);
		endfunction

		// sin/cos in Q30 of an angle in half-centidegrees
		function void sincos(longint a, output longint sn, output longint cs);
			bit flip;
			longint x, y, z, nx;
			flip = 0;
			x = 652032874;
			y = 0;
			a = a % 72000;
			if (a < 0)
				a += 72000;
			if (a >= 36000)
				a -= 72000;
			if (a > 18000) begin
				a -= 36000;
				flip = 1;
			end else if (a < -18000) begin
				a += 36000;
				flip = 1;
			end
			z = (a * 374807) >>> 2;
			for (int i = 0; i < 30; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z -= atan_q30[i];
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z += atan_q30[i];
				end
				x = nx;
			end
			sn = flip ? -y : y;
			cs = flip ? -x : x;
		endfunction

		// accepted request: advance the pose and queue the expected result
		function void note(odo_req_t rq);
			logic [15:0] h;
			longint df, ds, dh, lx, ly, sa, ca, sh, chh, s2, th, c;
			longint unsigned us2, uth;
			pose_t e;
			h = rq.hdg % 16'd36000;
			e.upd = 1'b1;
			if (rq.op == OP_SET_POSE) begin
				gx = longint'($signed(rq.nx));
				gy = longint'($signed(rq.ny));
				prev_hdg = h;
				n_pose++;
			end else if (rq.calib) begin
				e.upd = 1'b0;
				n_skip++;
			end else begin
				df = arc_len(rq.fwd, prev_fwd);
				ds = arc_len(rq.side, prev_side);
				dh = longint'(h) - longint'(prev_hdg);
				prev_fwd = rq.fwd;
				prev_side = rq.side;
				prev_hdg = h;
				if (dh > 18000)
					dh -= 36000;
				else if (dh <= -18000)
					dh += 36000;
				if (dh == 0) begin
					lx = ds;
					ly = df;
				end else begin
					// chord-arc local offset
					sincos(dh, sh, chh);
					s2 = 2 * sh;
					th = dh * 187403;
					us2 = (s2 < 0) ? longint'(-s2) : longint'(s2);
					uth = (th < 0) ? longint'(-th) : longint'(th);
					c = longint'((us2 << 30) / uth);
					lx = ((c * ds) >>> 30) + ((s2 * longint'($signed(side_off))) >>> 30);
					ly = ((c * df) >>> 30) - ((s2 * longint'($signed(fwd_off))) >>> 30);
				end
				// rotate by mid-arc heading
				sincos(2 * longint'(h) - dh, sa, ca);
				gx = clip32(gx + ((ly * sa) >>> 30) + ((lx * ca) >>> 30));
				gy = clip32(gy + ((ly * ca) >>> 30) - ((lx * sa) >>> 30));
				n_upd++;
			end
			e.x = gx[31:0];
			e.y = gy[31:0];
			pending.push_back(e);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("mismatch %s: got %h, expected %h", what, got, want);
		endtask

		task check(logic [31:0] x, logic [31:0] y, logic upd);
			pose_t e;
			if (pending.size() == 0) begin
				report("unexpected result", x, 32'd0);
			end else begin
				e = pending.pop_front();
				if (x !== e.x)
					report("pos_x", x, e.x);
				if (y !== e.y)
					report("pos_y", y, e.y);
				if (upd !== e.upd)
					report("updated", {31'd0, upd}, {31'd0, e.upd});
			end
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic [0:0]   m_tuser;
	logic         cfg_we;
	logic [1:0]   cfg_addr;
	logic [23:0]  cfg_wdata;

	pose_scoreboard sb;
	int           out_hold;
	bit           no_gaps;
	logic [31:0]  drv_fwd;
	logic [31:0]  drv_side;
	logic [15:0]  drv_hdg;

	tracking_wheel_odometry u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// offer one request and wait for its handshake
	task send_req(odo_req_t rq);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {rq.ny, rq.nx, rq.hdg, rq.side, rq.fwd};
		s_tuser <= {rq.calib, rq.op};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note(rq);
		@(negedge clk);
	endtask

	task put(logic op, logic calib, logic [31:0] fwd, logic [31:0] side, logic [15:0] hdg,
			logic [31:0] nx, logic [31:0] ny);
		odo_req_t rq;
		rq = '{op, calib, fwd, side, hdg, nx, ny};
		send_req(rq);
	endtask

	task write_reg(logic [1:0] idx, logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function logic [31:0] step_angle(logic [31:0] was);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1, 2: return was + 32'(int'($urandom_range(0, 2097152)) - 1048576);
			default: return was + 32'(int'($urandom_range(0, 10000)) - 5000);
		endcase
	endfunction

	// mostly coherent motion, some noise
	task random_req();
		odo_req_t rq;
		int r;
		r = $urandom_range(0, 99);
		rq.op = (r < 8) ? OP_SET_POSE : OP_UPDATE;
		rq.calib = (r >= 8 && r < 16) || ($urandom_range(0, 9) == 0);
		rq.fwd = step_angle(drv_fwd);
		rq.side = step_angle(drv_side);
		case ($urandom_range(0, 9))
			0: rq.hdg = 16'($urandom);
			1: rq.hdg = (drv_hdg + 16'd18000) % 16'd36000;
			2: rq.hdg = drv_hdg;
			default: rq.hdg = 16'((int'(drv_hdg % 16'd36000) + 36000 +
				int'($urandom_range(0, 2000)) - 1000) % 36000);
		endcase
		rq.nx = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed(int'($urandom_range(0,
			20000000)) - 10000000));
		rq.ny = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed(int'($urandom_range(0,
			20000000)) - 10000000));
		drv_fwd = rq.fwd;
		drv_side = rq.side;
		drv_hdg = rq.hdg % 16'd36000;
		send_req(rq);
	endtask

	// result side with random stalls
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (out_hold > 0) begin
				m_tready <= 1'b0;
				repeat (out_hold) @(negedge clk);
				out_hold = 0;
			end
			gap = no_gaps ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			sb.check(m_tdata[31:0], m_tdata[63:32], m_tuser[0]);
		end
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		logic [23:0] radii[5];
		logic [23:0] foffs[5];
		logic [23:0] soffs[5];
		sb = new();
		out_hold = 0;
		no_gaps = 0;
		drv_fwd = '0;
		drv_side = '0;
		drv_hdg = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset defaults first
		put(OP_UPDATE, 0, 32'd3000, 32'd1500, 16'd0, 0, 0);
		drain();
		write_reg(REG_FWD_OFFSET, 24'd327680);
		write_reg(REG_SIDE_OFFSET, 24'hFB0000);
		put(OP_UPDATE, 0, 32'd6000, 32'd1000, 16'd9000, 0, 0);
		// half-turn heading change twice, both taken as a positive half turn
		put(OP_UPDATE, 0, 32'd7000, 32'd1000, 16'd27000, 0, 0);
		put(OP_UPDATE, 0, 32'd7500, 32'd900, 16'd9000, 0, 0);
		// heading above range, top of the field
		put(OP_UPDATE, 0, 32'd7600, 32'd900, 16'hFFFF, 0, 0);
		put(OP_UPDATE, 0, 32'd7600, 32'd900, 16'd36000, 0, 0);
		// calibrating update is skipped, set pose ignores it
		put(OP_UPDATE, 1, 32'h12345678, 32'h87654321, 16'd100, 0, 0);
		put(OP_SET_POSE, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'd35999, 32'h7FFFFFFF,
			32'h80000000);
		// saturate the position with a big forward move
		put(OP_UPDATE, 0, 32'h7FFFFFF0, 32'h80000000, 16'd35999, 0, 0);
		// encoder wrap
		put(OP_UPDATE, 0, 32'h80000010, 32'h7FFFFFFF, 16'd35999, 0, 0);
		put(OP_SET_POSE, 0, 0, 0, 16'd0, 32'h0, 32'h0);
		put(OP_UPDATE, 0, 32'h80000010, 32'h7FFFFFFF, 16'd1, 0, 0);
		put(OP_UPDATE, 0, 32'h00000010, 32'hFFFFFFFF, 16'd35999, 0, 0);
		drv_fwd = 32'h10;
		drv_side = 32'hFFFFFFFF;
		drv_hdg = 16'd35999;

		// register settings: extremes and typical
		radii = '{24'd65536, 24'hFFFFFF, 24'd0, 24'd180000, 24'd1};
		foffs = '{24'd327680, 24'h7FFFFF, 24'h800000, 24'hFF0000, 24'd0};
		soffs = '{24'hFB0000, 24'h800000, 24'h7FFFFF, 24'd200000, 24'd0};
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			write_reg(REG_WHEEL_RADIUS, radii[ph]);
			write_reg(REG_FWD_OFFSET, foffs[ph]);
			write_reg(REG_SIDE_OFFSET, soffs[ph]);
			no_gaps = (ph == 3);
			if (ph == 2)
				out_hold = 400;
			for (int i = 0; i < 265; i++)
				random_req();
		end

		drain();
		$display("covered %0d updates, %0d set-pose requests, %0d skipped updates",
			sb.n_upd, sb.n_pose, sb.n_skip);
		$display("over 5 register settings with random gaps and one long output stall");
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
